@@ src/tpc_pkg.sv @@
package tpc_pkg;

	// fixed field and register widths
	localparam int PIX_W = 8;
	localparam int THR_W = 8;
	localparam int FW_W = 11;
	localparam int CTR_OUT_W = 10;

	// register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_FRAME_WIDTH = 1'b1;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd254;
	localparam logic [FW_W-1:0] WIDTH_RESET = 11'd640;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [FW_W-1:0] frame_width;
	} cfg_t;

	typedef struct packed {
		logic hit;
		logic last;
	} pix_flags_t;

endpackage

@@ src/threshold_pixel_centroid_top.sv @@
// Channel   Handshake                    Payload
// in        in_valid / in_ready          pixel_value, last_in_frame
// out       out_valid / out_ready        above_threshold, frame_done, found,
//                                        center_x, center_y
// cfg       psel, penable, pwrite        paddr, pwdata -> prdata, pready
//
// A pixel word is accepted whenever the queue is not full; words that end no frame leave
// at one per cycle while the back is idle and out_ready is high. An end-of-frame word
// with hits holds the back during its divide; a full four-word queue stalls the input.
// Results leave in order through a registered output; out_ready low holds it and backs up
// the queue. Reset clears position, accumulators, queue and output valid; registers
// return to threshold 254 and width 640.
module threshold_pixel_centroid_top import tpc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 last_in_frame,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 above_threshold,
	output logic                 frame_done,
	output logic                 found,
	output logic [CTR_OUT_W-1:0] center_x,
	output logic [CTR_OUT_W-1:0] center_y,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int QW = (CW > RW) ? CW : RW;
	localparam int HW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int SW = QW + HW;
	localparam int DW = $bits(pix_flags_t) + 2 * SW + HW;

	cfg_t cfg_q;

	logic          push;
	pix_flags_t    push_flags;
	logic [SW-1:0] push_col_sum;
	logic [SW-1:0] push_row_sum;
	logic [HW-1:0] push_count;
	logic          q_full;
	logic          q_valid;
	logic          q_pop;
	logic [DW-1:0] q_data;
	pix_flags_t    q_flags;
	logic [SW-1:0] q_col_sum;
	logic [SW-1:0] q_row_sum;
	logic [HW-1:0] q_count;
	logic          wr_en;

	// register file
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.frame_width <= WIDTH_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_THRESHOLD) begin
				cfg_q.threshold <= pwdata[THR_W-1:0];
			end else begin
				cfg_q.frame_width <= pwdata[FW_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_FRAME_WIDTH) begin
			prdata = DATA_W'(cfg_q.frame_width);
		end else begin
			prdata = DATA_W'(cfg_q.threshold);
		end
	end

	tpc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW),
		.RW        (RW),
		.HW        (HW),
		.SW        (SW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.last_in_frame(last_in_frame),
		.q_full       (q_full),
		.push         (push),
		.push_flags   (push_flags),
		.push_col_sum (push_col_sum),
		.push_row_sum (push_row_sum),
		.push_count   (push_count)
	);

	tpc_queue #(
		.DW(DW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_flags, push_col_sum, push_row_sum, push_count}),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.data     (q_data)
	);

	assign {q_flags, q_col_sum, q_row_sum, q_count} = q_data;

	tpc_back #(
		.QW(QW),
		.HW(HW),
		.SW(SW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_flags        (q_flags),
		.q_col_sum      (q_col_sum),
		.q_row_sum      (q_row_sum),
		.q_count        (q_count),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.above_threshold(above_threshold),
		.frame_done     (frame_done),
		.found          (found),
		.center_x       (center_x),
		.center_y       (center_y)
	);

endmodule

@@ src/tpc_front.sv @@
module tpc_front import tpc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int CW = 10,
	parameter int RW = 10,
	parameter int HW = 21,
	parameter int SW = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             last_in_frame,
	input  logic             q_full,
	output logic             push,
	output pix_flags_t       push_flags,
	output logic [SW-1:0]    push_col_sum,
	output logic [SW-1:0]    push_row_sum,
	output logic [HW-1:0]    push_count
);

	localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
	localparam int CAP = MAX_WIDTH * MAX_HEIGHT;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] col_sum_q;
	logic [SW-1:0] row_sum_q;
	logic [HW-1:0] cnt_q;

	logic          hit;
	logic          take;
	logic [EW-1:0] fw_ext;
	logic [EW-1:0] eff_w;
	logic [EW-1:0] col_inc;
	logic          col_wrap;
	logic          row_wrap;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;

	// classify the pixel and decide whether it is accumulated
	always_comb begin
		hit = pixel_value > cfg.threshold;
		take = hit && (cnt_q < HW'(CAP));
		push_flags.hit = hit;
		push_flags.last = last_in_frame;
		push_col_sum = take ? col_sum_q + SW'(col_q) : col_sum_q;
		push_row_sum = take ? row_sum_q + SW'(row_q) : row_sum_q;
		push_count = take ? cnt_q + HW'(1) : cnt_q;
	end

	// clamp the width and find the wrap points
	always_comb begin
		fw_ext = EW'(cfg.frame_width);
		if (fw_ext == '0) begin
			eff_w = EW'(1);
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
		col_inc = EW'(col_q) + EW'(1);
		col_wrap = col_inc >= eff_w;
		row_wrap = row_q == RW'(MAX_HEIGHT - 1);
	end

	// advance position and accumulators, clear at end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
			cnt_q <= '0;
		end else if (push) begin
			if (last_in_frame) begin
				col_q <= '0;
				row_q <= '0;
				col_sum_q <= '0;
				row_sum_q <= '0;
				cnt_q <= '0;
			end else begin
				col_sum_q <= push_col_sum;
				row_sum_q <= push_row_sum;
				cnt_q <= push_count;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HW'(CAP))
		else $error("hit count above capacity");

endmodule

@@ src/tpc_queue.sv @@
module tpc_queue import tpc_pkg::*; #(
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output logic [DW-1:0] data
);

	logic [DW-1:0]     mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = cnt_q == QCNT_W'(QDEPTH);
	assign valid = cnt_q != '0;
	assign data = mem_q[rd_ptr_q];

	// store words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue underflow");

endmodule

@@ src/tpc_back.sv @@
module tpc_back import tpc_pkg::*; #(
	parameter int QW = 10,
	parameter int HW = 21,
	parameter int SW = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  pix_flags_t           q_flags,
	input  logic [SW-1:0]        q_col_sum,
	input  logic [SW-1:0]        q_row_sum,
	input  logic [HW-1:0]        q_count,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 above_threshold,
	output logic                 frame_done,
	output logic                 found,
	output logic [CTR_OUT_W-1:0] center_x,
	output logic [CTR_OUT_W-1:0] center_y
);

	localparam int IW = $clog2(QW + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] iter_q;
	logic [SW-1:0] rem_x_q;
	logic [SW-1:0] rem_y_q;
	logic [SW-1:0] div_q;
	logic [QW-1:0] quo_x_q;
	logic [QW-1:0] quo_y_q;
	logic          hit_q;
	logic          out_valid_q;

	logic                   out_free;
	logic                   start_div;
	logic                   load_direct;
	logic                   load_div;
	logic                   ge_x;
	logic                   ge_y;
	logic [QW+CTR_OUT_W-1:0] ext_x;
	logic [QW+CTR_OUT_W-1:0] ext_y;

	assign out_valid = out_valid_q;

	// pop a word when idle and the output slot frees up
	always_comb begin
		out_free = !out_valid_q || out_ready;
		q_pop = (state_q == ST_IDLE) && q_valid && out_free;
		start_div = q_pop && q_flags.last && (q_count != '0);
		load_direct = q_pop && !start_div;
		load_div = (state_q == ST_OUT) && out_free;
		ge_x = rem_x_q >= div_q;
		ge_y = rem_y_q >= div_q;
		ext_x = {{CTR_OUT_W{1'b0}}, quo_x_q};
		ext_y = {{CTR_OUT_W{1'b0}}, quo_y_q};
	end

	// sequence the restoring divide, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_div) begin
						state_q <= ST_DIV;
						iter_q <= IW'(QW - 1);
					end
				end
				ST_DIV: begin
					if (iter_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						iter_q <= iter_q - IW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start_div) begin
			rem_x_q <= q_col_sum;
			rem_y_q <= q_row_sum;
			div_q <= SW'(q_count) << (QW - 1);
			quo_x_q <= '0;
			quo_y_q <= '0;
			hit_q <= q_flags.hit;
		end else if (state_q == ST_DIV) begin
			if (ge_x) begin
				rem_x_q <= rem_x_q - div_q;
			end
			if (ge_y) begin
				rem_y_q <= rem_y_q - div_q;
			end
			quo_x_q <= QW'({quo_x_q, ge_x});
			quo_y_q <= QW'({quo_y_q, ge_y});
			div_q <= div_q >> 1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_div) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			above_threshold <= q_flags.hit;
			frame_done <= q_flags.last;
			found <= 1'b0;
			center_x <= '0;
			center_y <= '0;
		end else if (load_div) begin
			above_threshold <= hit_q;
			frame_done <= 1'b1;
			found <= 1'b1;
			center_x <= ext_x[CTR_OUT_W-1:0];
			center_y <= ext_y[CTR_OUT_W-1:0];
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0 || iter_q == '0 || QW == 1))
		else $error("divisor shifted out early");

	a_found_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found) |-> frame_done)
		else $error("found outside end of frame");

endmodule
